FILE: hdl/cwc_pkg.sv
// ----------------------------------------------------------------------------
// cwc_pkg
// Shared types, register indexes and lookup tables of the contactor weld check.
// ----------------------------------------------------------------------------
package cwc_pkg;

   localparam int EDGE_COUNT_BITS = 16;
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 16;

   typedef logic [EDGE_COUNT_BITS-1:0] edge_cnt_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FEEDBACK_MODE  = 3'd0,
      CSR_RELAY_INVERTED = 3'd1,
      CSR_WINDOW_MS      = 3'd2,
      CSR_EDGE_THRESHOLD = 3'd3,
      CSR_DEBOUNCE_MS    = 3'd4
   } csr_index_type;

   localparam logic KIND_SAMPLE    = 1'b0;
   localparam logic KIND_SKIP_LOAD = 1'b1;

   localparam logic [15:0] WINDOW_MS_RESET      = 16'd250;
   localparam logic [7:0]  EDGE_THRESHOLD_RESET = 8'd10;
   localparam logic [15:0] DEBOUNCE_MS_RESET    = 16'd250;

   // feedback code (aux, phase aux, n/l1, l2/l3) to error code, ok codes give zero
   localparam logic [3:0] FB_CODE_MAP [16] = '{
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd0, 4'd5, 4'd6,
      4'd7, 4'd8, 4'd9, 4'd0, 4'd10, 4'd11, 4'd12, 4'd0
   };

   // ac verdict indexed by the two live bits
   localparam logic [2:0] AC_ERR_ON  [4] = '{3'd1, 3'd2, 3'd3, 3'd0};
   localparam logic [2:0] AC_ERR_OFF [4] = '{3'd4, 3'd0, 3'd5, 3'd6};

   typedef struct packed {
      logic       kind;
      logic       ms_tick;
      logic       ac1_pin;
      logic       ac2_pin;
      logic       relay_pin;
      logic       fb_n_l1_pin;
      logic       fb_l2_l3_pin;
      logic       earth_pin;
      logic       contactor_aux_pin;
      logic       phase_aux_pin;
      logic [7:0] skip_windows;
   } req_type;

   typedef struct packed {
      logic [4:0] status_bits;
      logic [4:0] error_code;
   } rsp_type;

   typedef struct packed {
      logic        feedback_mode;
      logic        relay_inverted;
      logic [15:0] window_ms;
      logic [7:0]  edge_threshold;
      logic [15:0] debounce_ms;
   } cfg_type;

endpackage

FILE: hdl/cwc_csr.sv
// ----------------------------------------------------------------------------
// cwc_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module cwc_csr
   import cwc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FEEDBACK_MODE:  cfg_in.feedback_mode  = csr_wdata[0];
            CSR_RELAY_INVERTED: cfg_in.relay_inverted = csr_wdata[0];
            CSR_WINDOW_MS:      cfg_in.window_ms      = csr_wdata[15:0];
            CSR_EDGE_THRESHOLD: cfg_in.edge_threshold = csr_wdata[7:0];
            CSR_DEBOUNCE_MS:    cfg_in.debounce_ms    = csr_wdata[15:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.feedback_mode  <= 1'b0;
         cfg_ff.relay_inverted <= 1'b0;
         cfg_ff.window_ms      <= WINDOW_MS_RESET;
         cfg_ff.edge_threshold <= EDGE_THRESHOLD_RESET;
         cfg_ff.debounce_ms    <= DEBOUNCE_MS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/cwc_core.sv
// ----------------------------------------------------------------------------
// cwc_core
// Checker state and the single-pass update for one beat.
// ----------------------------------------------------------------------------
module cwc_core
   import cwc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    step_en,
   input  req_type item,
   input  cfg_type cfg,
   output rsp_type result
);

   logic         primed_ff, primed_in;
   logic         ac1_prev_ff, ac2_prev_ff, earth_prev_ff;
   logic         ac1_prev_in, ac2_prev_in, earth_prev_in;
   edge_cnt_type ac1_edges_ff, ac2_edges_ff, earth_edges_ff;
   edge_cnt_type ac1_edges_in, ac2_edges_in, earth_edges_in;
   logic [15:0]  window_count_ff, window_count_in;
   logic [7:0]   skip_count_ff, skip_count_in;
   logic [15:0]  error_age_ff, error_age_in;
   logic         error_pending_ff, error_pending_in;
   logic [4:0]   error_reg_ff, error_reg_in;
   logic [4:0]   status_reg_ff, status_reg_in;

   logic         active;
   logic [15:0]  window_inc;
   logic         ended;
   logic         take;
   logic [1:0]   live;
   logic         relay_on;
   logic [3:0]   code;
   logic [15:0]  age_next;
   edge_cnt_type thr_ext;

   assign thr_ext = edge_cnt_type'(cfg.edge_threshold);
   // a counting sample: pin sample after priming
   assign active  = (item.kind == KIND_SAMPLE) && primed_ff;

   // shared window timer
   always_comb begin
      window_inc      = (window_count_ff != 16'hFFFF) ? window_count_ff + 16'd1
                                                      : window_count_ff;
      ended           = 1'b0;
      take            = 1'b0;
      window_count_in = window_count_ff;
      skip_count_in   = skip_count_ff;
      if (item.kind == KIND_SKIP_LOAD) begin
         skip_count_in = item.skip_windows;
      end else if (active && item.ms_tick) begin
         if (window_inc >= cfg.window_ms) begin
            window_count_in = 16'd0;
            ended           = 1'b1;
            if (skip_count_ff != 8'd0) begin
               skip_count_in = skip_count_ff - 8'd1;
            end else begin
               take = 1'b1;
            end
         end else begin
            window_count_in = window_inc;
         end
      end
   end

   always_comb begin
      primed_in        = primed_ff;
      ac1_edges_in     = ac1_edges_ff;
      ac2_edges_in     = ac2_edges_ff;
      earth_edges_in   = earth_edges_ff;
      error_age_in     = error_age_ff;
      error_pending_in = error_pending_ff;
      error_reg_in     = error_reg_ff;
      status_reg_in    = status_reg_ff;
      live             = 2'b00;
      relay_on         = item.relay_pin ^ cfg.relay_inverted;
      code = FB_CODE_MAP[{item.contactor_aux_pin, item.phase_aux_pin,
                          item.fb_n_l1_pin, item.fb_l2_l3_pin}];
      age_next = (item.ms_tick && error_age_ff != 16'hFFFF) ? error_age_ff + 16'd1
                                                            : error_age_ff;

      if (item.kind == KIND_SAMPLE && !primed_ff) begin
         primed_in = 1'b1;
      end else if (active && !cfg.feedback_mode) begin
         if (item.ac1_pin != ac1_prev_ff && ac1_edges_ff != '1) begin
            ac1_edges_in = ac1_edges_ff + edge_cnt_type'(1);
         end
         if (item.ac2_pin != ac2_prev_ff && ac2_edges_ff != '1) begin
            ac2_edges_in = ac2_edges_ff + edge_cnt_type'(1);
         end
         live = {ac2_edges_in > thr_ext, ac1_edges_in > thr_ext};
         if (take) begin
            status_reg_in = {3'b000, live};
            error_reg_in  = {2'b00, relay_on ? AC_ERR_ON[live] : AC_ERR_OFF[live]};
         end
         if (ended) begin
            ac1_edges_in = '0;
            ac2_edges_in = '0;
         end
      end else if (active) begin
         if (item.earth_pin != earth_prev_ff && earth_edges_ff != '1) begin
            earth_edges_in = earth_edges_ff + edge_cnt_type'(1);
         end
         if (take) begin
            error_reg_in = {4'd0, !(earth_edges_in > thr_ext)};
         end
         if (ended) begin
            earth_edges_in = '0;
         end
         error_reg_in = {4'd0, error_reg_in[0]};
         if (code == 4'd0) begin
            error_pending_in = 1'b0;
            error_age_in     = 16'd0;
         end else if (!error_pending_ff) begin
            error_pending_in = 1'b1;
            error_age_in     = 16'd0;
         end else begin
            error_age_in = age_next;
            if (age_next >= cfg.debounce_ms) begin
               error_reg_in = {code, error_reg_in[0]};
            end
         end
         status_reg_in = {!item.phase_aux_pin, !item.contactor_aux_pin,
                          error_reg_in != 5'd0, !item.fb_l2_l3_pin, !item.fb_n_l1_pin};
      end
   end

   // edge history follows every pin sample
   assign ac1_prev_in   = (item.kind == KIND_SAMPLE) ? item.ac1_pin   : ac1_prev_ff;
   assign ac2_prev_in   = (item.kind == KIND_SAMPLE) ? item.ac2_pin   : ac2_prev_ff;
   assign earth_prev_in = (item.kind == KIND_SAMPLE) ? item.earth_pin : earth_prev_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff        <= 1'b0;
         ac1_prev_ff      <= 1'b0;
         ac2_prev_ff      <= 1'b0;
         earth_prev_ff    <= 1'b0;
         ac1_edges_ff     <= '0;
         ac2_edges_ff     <= '0;
         earth_edges_ff   <= '0;
         window_count_ff  <= 16'd0;
         skip_count_ff    <= 8'd0;
         error_age_ff     <= 16'd0;
         error_pending_ff <= 1'b0;
         error_reg_ff     <= 5'd0;
         status_reg_ff    <= 5'd0;
      end else if (step_en) begin
         primed_ff        <= primed_in;
         ac1_prev_ff      <= ac1_prev_in;
         ac2_prev_ff      <= ac2_prev_in;
         earth_prev_ff    <= earth_prev_in;
         ac1_edges_ff     <= ac1_edges_in;
         ac2_edges_ff     <= ac2_edges_in;
         earth_edges_ff   <= earth_edges_in;
         window_count_ff  <= window_count_in;
         skip_count_ff    <= skip_count_in;
         error_age_ff     <= error_age_in;
         error_pending_ff <= error_pending_in;
         error_reg_ff     <= error_reg_in;
         status_reg_ff    <= status_reg_in;
      end
   end

   assign result.status_bits = status_reg_in;
   assign result.error_code  = error_reg_in;

   // the window counter is cleared at the end of every window
   assert property (@(posedge clock) disable iff (reset)
      (step_en && ended) |=> (window_count_ff == 16'd0))
      else $error("window counter not cleared at window end");

   // the error age stays zero while no feedback error is pending
   assert property (@(posedge clock) disable iff (reset)
      !error_pending_ff |-> (error_age_ff == 16'd0))
      else $error("error age running without a pending error");

   // nothing is counted before the first sample primes the edge history
   assert property (@(posedge clock) disable iff (reset)
      !primed_ff |-> (ac1_edges_ff == '0 && window_count_ff == 16'd0))
      else $error("counting before the edge history was primed");

endmodule

FILE: hdl/contactor_weld_check.sv
// ----------------------------------------------------------------------------
// contactor_weld_check
// Contactor weld and feedback checker with input and result registers.
// ----------------------------------------------------------------------------
// Usage: pin samples (or skip-count loads) enter on the req_ channel, one
// beat per item; every beat produces exactly one rsp_ beat carrying the
// status bits and error code. Configuration is written on the csr_ port while
// the block is idle, one register per cycle, no read-back.
// Path: a beat accepted into the input register is processed into the result
// register when it advances and is offered on rsp_ from then on.
// Throughput: one beat per cycle while rsp_ready is high; all per-beat work
// is a single pass of counters and compares from input to result register.
// Stall: a full result register holds while rsp_ready is low; the input
// register keeps taking a beat until it too is full, then req_ready drops.
// Reset: synchronous; clears the checker state, both valid flags and loads the
// configuration reset values (window and debounce 250 ms, threshold 10).
// ----------------------------------------------------------------------------
module contactor_weld_check
   import cwc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   cfg_type cfg;
   req_type in_data_ff;
   logic    in_valid_ff;
   rsp_type out_data_ff;
   logic    out_valid_ff;
   rsp_type result;
   logic    advance;

   cwc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // move a beat from the input register into the result register
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   cwc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_data_ff),
      .cfg     (cfg),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("processed beat did not reach the result register");

   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("waiting input beat dropped");

   assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("empty input register refuses a beat");

endmodule
